// File: src/pim_subarray_bit_core_macros.svh
// Assertion helpers used by the checker file.
`ifndef PIM_SUBARRAY_BIT_CORE_MACROS_SVH
`define PIM_SUBARRAY_BIT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSBC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("psbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSBC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("psbc assertion failed");

`endif

// File: src/psbc_pkg.sv
`default_nettype none

package psbc_pkg;

    localparam int NUM_ROWS_DEF = 64;
    localparam int NUM_COLS_DEF = 64;

    localparam int OPCODE_W   = 4;
    localparam int INDEX_W    = 7;
    localparam int VALUE_W    = 64;
    localparam int WORD_W     = 32;
    localparam int WORD_BITS  = 32;
    localparam int WORD_IDX_W = $clog2(WORD_BITS);

    // Triple-row majority: three reads, then three write-backs.
    localparam int TRI_READS = 3;
    localparam int TRI_STEPS = 6;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RDROW   = 4'd0,
        OP_RDCOL   = 4'd1,
        OP_TRIROW  = 4'd2,
        OP_TRICOL  = 4'd3,
        OP_WRROW   = 4'd4,
        OP_WRCOL   = 4'd5,
        OP_LDROWSA = 4'd6,
        OP_LDCOLSA = 4'd7,
        OP_SETBIT  = 4'd8,
        OP_GETBIT  = 4'd9,
        OP_SETV    = 4'd10,
        OP_GETV    = 4'd11,
        OP_SETH    = 4'd12,
        OP_GETH    = 4'd13
    } op_t;

endpackage

`default_nettype wire

// File: src/psbc_ifs.sv
`default_nettype none

interface psbc_req_if;
    import psbc_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [INDEX_W-1:0]  first_index;
    logic [INDEX_W-1:0]  second_index;
    logic [INDEX_W-1:0]  third_index;
    logic [VALUE_W-1:0]  write_value;

    modport source (
        output valid, opcode, first_index, second_index, third_index, write_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, first_index, second_index, third_index, write_value,
        output ready
    );
endinterface

interface psbc_rsp_if;
    import psbc_pkg::*;

    logic               valid;
    logic               ready;
    logic               status;
    logic [WORD_W-1:0]  read_word;
    logic [VALUE_W-1:0] row_sense_value;
    logic [VALUE_W-1:0] col_sense_value;

    modport source (
        output valid, status, read_word, row_sense_value, col_sense_value,
        input  ready
    );
    modport sink (
        input  valid, status, read_word, row_sense_value, col_sense_value,
        output ready
    );
endinterface

`default_nettype wire

// File: src/psbc_ram.sv
`default_nettype none

module psbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single port, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: src/pim_subarray_bit_core.sv
// Sense loads and rejected items go straight to the result state. Other ops take a
// read and a modify state per row access: one access for single-row ops, six for
// triple-row (three reads, three write-backs), 32 for vertical words, NUM_ROWS for
// column ops. Items are taken only in idle, after the last result is registered; the
// single-port array memory takes a read per row access and a write-back if writing.
// Reset (async, active low): sense registers clear to zero; array is not cleared.
`default_nettype none

module pim_subarray_bit_core #(
    parameter int NUM_ROWS = psbc_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = psbc_pkg::NUM_COLS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    psbc_req_if.sink   req,
    psbc_rsp_if.source rsp
);
    import psbc_pkg::*;

    localparam int ROW_W = $clog2(NUM_ROWS);
    localparam int COL_W = $clog2(NUM_COLS);
    localparam int CHK_W = INDEX_W + 1;

    localparam logic [ROW_W-1:0]    LAST_ALL  = ROW_W'(NUM_ROWS - 1);
    localparam logic [ROW_W-1:0]    LAST_WORD = ROW_W'(WORD_BITS - 1);
    localparam logic [ROW_W-1:0]    LAST_TRI  = ROW_W'(TRI_STEPS - 1);
    localparam logic [ROW_W-1:0]    TRI_WR0   = ROW_W'(TRI_READS);
    localparam logic [NUM_COLS-1:0] H_MASK    = NUM_COLS'({WORD_BITS{1'b1}});

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_FINISH
    } state_t;

    // Control state
    state_t              state_reg, state_next;
    logic                out_valid_reg, out_valid_next;
    logic [NUM_COLS-1:0] row_sense_reg, row_sense_next;
    logic [NUM_ROWS-1:0] col_sense_reg, col_sense_next;

    // Item and datapath registers
    op_t                 op_reg, op_next;
    logic [INDEX_W-1:0]  a_reg, a_next;
    logic [INDEX_W-1:0]  b_reg, b_next;
    logic [INDEX_W-1:0]  c_reg, c_next;
    logic [WORD_W-1:0]   wv_reg, wv_next;
    logic [ROW_W-1:0]    idx_reg, idx_next;
    logic                err_reg, err_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [NUM_COLS-1:0] x_reg, x_next;
    logic [NUM_COLS-1:0] y_reg, y_next;
    logic [NUM_COLS-1:0] m_reg, m_next;

    // Result register
    logic                status_reg, status_next;
    logic [WORD_W-1:0]   read_word_reg, read_word_next;
    logic [VALUE_W-1:0]  row_out_reg, row_out_next;
    logic [VALUE_W-1:0]  col_out_reg, col_out_next;

    // Array memory port
    logic                ram_we;
    logic [ROW_W-1:0]    ram_addr;
    logic [NUM_COLS-1:0] ram_wdata;
    logic [NUM_COLS-1:0] ram_rdata;

    // Index decode
    logic [CHK_W-1:0]    a_chk, b_chk, c_chk;
    logic                req_err;
    logic [ROW_W-1:0]    a_row, b_row, c_row;
    logic [COL_W-1:0]    a_col, b_col, c_col;
    logic [1:0]          tri_lane;
    logic [ROW_W-1:0]    row_addr;
    logic [ROW_W-1:0]    last_idx;
    logic [NUM_COLS-1:0] row_maj;
    logic                bit_maj;
    logic [WORD_IDX_W-1:0] word_bit;

    psbc_ram #(
        .WIDTH (NUM_COLS),
        .DEPTH (NUM_ROWS)
    ) u_array (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = status_reg;
    assign rsp.read_word       = read_word_reg;
    assign rsp.row_sense_value = row_out_reg;
    assign rsp.col_sense_value = col_out_reg;

    // Range check of the incoming item; vertical and horizontal words need
    // all 32 bits inside the array.
    always_comb
    begin
        a_chk = {1'b0, req.first_index};
        b_chk = {1'b0, req.second_index};
        c_chk = {1'b0, req.third_index};
        unique case (op_t'(req.opcode))
            OP_RDROW, OP_WRROW:
                req_err = (a_chk >= CHK_W'(NUM_ROWS));
            OP_RDCOL, OP_WRCOL:
                req_err = (a_chk >= CHK_W'(NUM_COLS));
            OP_TRIROW:
                req_err = (a_chk >= CHK_W'(NUM_ROWS)) || (b_chk >= CHK_W'(NUM_ROWS))
                       || (c_chk >= CHK_W'(NUM_ROWS));
            OP_TRICOL:
                req_err = (a_chk >= CHK_W'(NUM_COLS)) || (b_chk >= CHK_W'(NUM_COLS))
                       || (c_chk >= CHK_W'(NUM_COLS));
            OP_LDROWSA, OP_LDCOLSA:
                req_err = 1'b0;
            OP_SETBIT, OP_GETBIT:
                req_err = (a_chk >= CHK_W'(NUM_ROWS)) || (b_chk >= CHK_W'(NUM_COLS));
            OP_SETV, OP_GETV:
                req_err = (a_chk + CHK_W'(WORD_BITS) > CHK_W'(NUM_ROWS))
                       || (b_chk >= CHK_W'(NUM_COLS));
            OP_SETH, OP_GETH:
                req_err = (a_chk >= CHK_W'(NUM_ROWS))
                       || (b_chk + CHK_W'(WORD_BITS) > CHK_W'(NUM_COLS));
            default:
                req_err = 1'b1;
        endcase
    end

    // Row sequencing for the held item. Indices are in range once the item
    // passed the check, so the low bits address the array directly.
    always_comb
    begin
        a_row = a_reg[ROW_W-1:0];
        b_row = b_reg[ROW_W-1:0];
        c_row = c_reg[ROW_W-1:0];
        a_col = a_reg[COL_W-1:0];
        b_col = b_reg[COL_W-1:0];
        c_col = c_reg[COL_W-1:0];

        // Triple-row: steps 0..2 read a, b, c; steps 3..5 write them back.
        if (idx_reg >= TRI_WR0)
        begin
            tri_lane = 2'(idx_reg - TRI_WR0);
        end
        else
        begin
            tri_lane = 2'(idx_reg);
        end

        unique case (op_reg)
            OP_RDCOL, OP_TRICOL, OP_WRCOL:
            begin
                row_addr = idx_reg;
                last_idx = LAST_ALL;
            end
            OP_SETV, OP_GETV:
            begin
                row_addr = a_row + idx_reg;
                last_idx = LAST_WORD;
            end
            OP_TRIROW:
            begin
                if (tri_lane == 2'd0)
                begin
                    row_addr = a_row;
                end
                else if (tri_lane == 2'd1)
                begin
                    row_addr = b_row;
                end
                else
                begin
                    row_addr = c_row;
                end
                last_idx = LAST_TRI;
            end
            default:
            begin
                row_addr = a_row;
                last_idx = '0;
            end
        endcase

        row_maj  = (x_reg & y_reg) | (x_reg & ram_rdata) | (y_reg & ram_rdata);
        bit_maj  = (ram_rdata[a_col] & ram_rdata[b_col]) | (ram_rdata[a_col] & ram_rdata[c_col])
                 | (ram_rdata[b_col] & ram_rdata[c_col]);
        word_bit = idx_reg[WORD_IDX_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        row_sense_next = row_sense_reg;
        col_sense_next = col_sense_reg;
        op_next        = op_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        wv_next        = wv_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        word_next      = word_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        m_next         = m_reg;
        status_next    = status_reg;
        read_word_next = read_word_reg;
        row_out_next   = row_out_reg;
        col_out_next   = col_out_reg;
        ram_we         = 1'b0;
        ram_addr       = row_addr;
        ram_wdata      = ram_rdata;

        // Drop the result once the sink takes it.
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next   = op_t'(req.opcode);
                    a_next    = req.first_index;
                    b_next    = req.second_index;
                    c_next    = req.third_index;
                    wv_next   = req.write_value[WORD_W-1:0];
                    idx_next  = '0;
                    word_next = '0;
                    err_next  = req_err;
                    if (req_err)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (op_t'(req.opcode) == OP_LDROWSA)
                    begin
                        row_sense_next = req.write_value[NUM_COLS-1:0];
                        state_next     = S_FINISH;
                    end
                    else if (op_t'(req.opcode) == OP_LDCOLSA)
                    begin
                        col_sense_next = req.write_value[NUM_ROWS-1:0];
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_MODIFY;
            end

            S_MODIFY:
            begin
                ram_wdata = ram_rdata;
                unique case (op_reg)
                    OP_RDROW:
                        row_sense_next = ram_rdata;
                    OP_RDCOL:
                        col_sense_next[idx_reg] = ram_rdata[a_col];
                    OP_TRIROW:
                    begin
                        if (idx_reg >= TRI_WR0)
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = m_reg;
                        end
                        else if (tri_lane == 2'd0)
                        begin
                            x_next = ram_rdata;
                        end
                        else if (tri_lane == 2'd1)
                        begin
                            y_next = ram_rdata;
                        end
                        else
                        begin
                            m_next         = row_maj;
                            row_sense_next = row_maj;
                        end
                    end
                    OP_TRICOL:
                    begin
                        ram_we           = 1'b1;
                        ram_wdata[a_col] = bit_maj;
                        ram_wdata[b_col] = bit_maj;
                        ram_wdata[c_col] = bit_maj;
                        col_sense_next[idx_reg] = bit_maj;
                    end
                    OP_WRROW:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = row_sense_reg;
                    end
                    OP_WRCOL:
                    begin
                        ram_we           = 1'b1;
                        ram_wdata[a_col] = col_sense_reg[idx_reg];
                    end
                    OP_SETBIT:
                    begin
                        ram_we           = 1'b1;
                        ram_wdata[b_col] = wv_reg[0];
                    end
                    OP_GETBIT:
                        word_next = WORD_W'(ram_rdata[b_col]);
                    OP_SETV:
                    begin
                        ram_we           = 1'b1;
                        ram_wdata[b_col] = wv_reg[word_bit];
                    end
                    OP_GETV:
                        word_next[word_bit] = ram_rdata[b_col];
                    OP_SETH:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = (ram_rdata & ~(H_MASK << b_col))
                                  | (NUM_COLS'(wv_reg) << b_col);
                    end
                    OP_GETH:
                        word_next = WORD_W'(ram_rdata >> b_col);
                    default:
                    begin
                    end
                endcase

                // Advance to the next row, or close the item.
                if (idx_reg == last_idx)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + ROW_W'(1);
                    state_next = S_READ;
                end
            end

            S_FINISH:
            begin
                // Hold until the result register is free.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = err_reg;
                    read_word_next = word_reg;
                    row_out_next   = VALUE_W'(row_sense_reg);
                    col_out_next   = VALUE_W'(col_sense_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            row_sense_reg <= '0;
            col_sense_reg <= '0;
            status_reg    <= 1'b0;
            read_word_reg <= '0;
            row_out_reg   <= '0;
            col_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            row_sense_reg <= row_sense_next;
            col_sense_reg <= col_sense_next;
            status_reg    <= status_next;
            read_word_reg <= read_word_next;
            row_out_reg   <= row_out_next;
            col_out_reg   <= col_out_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        wv_reg        <= wv_next;
        idx_reg       <= idx_next;
        err_reg       <= err_next;
        word_reg      <= word_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        m_reg         <= m_next;
    end

endmodule

`default_nettype wire

// File: src/psbc_checker.sv
`default_nettype none

`include "pim_subarray_bit_core_macros.svh"

module psbc_checker #(
    parameter int NUM_ROWS = psbc_pkg::NUM_ROWS_DEF,
    parameter int NUM_COLS = psbc_pkg::NUM_COLS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          req_valid,
    input wire logic                          req_ready,
    input wire logic                          rsp_valid,
    input wire logic                          rsp_ready,
    input wire logic                          rsp_status,
    input wire logic [psbc_pkg::WORD_W-1:0]   rsp_read_word,
    input wire logic [psbc_pkg::VALUE_W-1:0]  rsp_row_sense_value,
    input wire logic [psbc_pkg::VALUE_W-1:0]  rsp_col_sense_value
);
    import psbc_pkg::*;

    // One item in flight: ready drops right after an accept.
    `PSBC_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready)

    // Errors return a zero word.
    `PSBC_ASSERT_NOW(a_err_word_zero, clk, rst_n, rsp_valid && rsp_status,
        rsp_read_word == '0)

    // Sense values never carry bits past the array size.
    `PSBC_ASSERT_NOW(a_row_sense_width, clk, rst_n, rsp_valid,
        (rsp_row_sense_value >> NUM_COLS) == '0)
    `PSBC_ASSERT_NOW(a_col_sense_width, clk, rst_n, rsp_valid,
        (rsp_col_sense_value >> NUM_ROWS) == '0)

    // A stalled result stays valid with its status unchanged.
    `PSBC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(rsp_status))

endmodule

bind pim_subarray_bit_core psbc_checker #(
    .NUM_ROWS (NUM_ROWS),
    .NUM_COLS (NUM_COLS)
) u_psbc_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .req_valid           (req.valid),
    .req_ready           (req.ready),
    .rsp_valid           (rsp.valid),
    .rsp_ready           (rsp.ready),
    .rsp_status          (rsp.status),
    .rsp_read_word       (rsp.read_word),
    .rsp_row_sense_value (rsp.row_sense_value),
    .rsp_col_sense_value (rsp.col_sense_value)
);

`default_nettype wire

// File: tb/tb_pim_subarray_bit_core.sv
`timescale 1ns / 1ps

module tb_pim_subarray_bit_core;
    import psbc_pkg::*;

    localparam int N_ROWS = NUM_ROWS_DEF;
    localparam int N_COLS = NUM_COLS_DEF;

    // Opcodes the block does not define; both must come back as errors.
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 4'd14;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 4'd15;

    // Valid start positions for a 32-bit word run down a column or along a row.
    localparam int V_STARTS = N_ROWS - WORD_BITS + 1;
    localparam int H_STARTS = N_COLS - WORD_BITS + 1;

    // Longest correct gap between two handshakes is one column operation plus a
    // random receiver stall; allow far more.
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_OFF    = 2 * N_ROWS + 20;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic               status;
        logic [WORD_W-1:0]  read_word;
        logic [VALUE_W-1:0] row_sense_value;
        logic [VALUE_W-1:0] col_sense_value;
    } subarray_result_t;

    logic clk;
    logic rst_n;

    psbc_req_if req_bus ();
    psbc_rsp_if rsp_bus ();

    pim_subarray_bit_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Mirror of the subarray: cell (r, c) is mirror_cells[r][c]. The row sense
    // register has one bit per column, the column sense register one per row.
    logic [VALUE_W-1:0] mirror_cells [N_ROWS];
    logic [VALUE_W-1:0] mirror_row_sense;
    logic [VALUE_W-1:0] mirror_col_sense;

    subarray_result_t awaited_results [$];

    int mismatch_count;
    int quiet_cycles;
    int src_idle_pct;
    int snk_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Print the mismatch (up to a cap, so a broken block cannot flood the log)
    // and count it.
    task automatic flag_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Apply one accepted item to the mirror and queue the result it must give.
    // An error of any kind leaves the array and both sense registers alone.
    task automatic apply_to_mirror(input logic [OPCODE_W-1:0] opc,
                                   input logic [INDEX_W-1:0] a,
                                   input logic [INDEX_W-1:0] b,
                                   input logic [INDEX_W-1:0] c,
                                   input logic [VALUE_W-1:0] wv);
        subarray_result_t res;
        logic x, y, z, m;
        int i;
        res = '0;
        case (opc)
            OP_RDROW:
                if (a >= N_ROWS) res.status = 1'b1;
                else mirror_row_sense = mirror_cells[a];
            OP_RDCOL:
                if (a >= N_COLS) res.status = 1'b1;
                else
                begin
                    for (i = 0; i < N_ROWS; i++)
                        mirror_col_sense[i] = mirror_cells[i][a];
                end
            OP_TRIROW:
                if (a >= N_ROWS || b >= N_ROWS || c >= N_ROWS) res.status = 1'b1;
                else
                begin
                    // Bitwise majority of the three rows lands in all three.
                    mirror_row_sense = (mirror_cells[a] & mirror_cells[b])
                                     | (mirror_cells[a] & mirror_cells[c])
                                     | (mirror_cells[b] & mirror_cells[c]);
                    mirror_cells[a] = mirror_row_sense;
                    mirror_cells[b] = mirror_row_sense;
                    mirror_cells[c] = mirror_row_sense;
                end
            OP_TRICOL:
                if (a >= N_COLS || b >= N_COLS || c >= N_COLS) res.status = 1'b1;
                else
                begin
                    for (i = 0; i < N_ROWS; i++)
                    begin
                        x = mirror_cells[i][a];
                        y = mirror_cells[i][b];
                        z = mirror_cells[i][c];
                        m = (x & y) | (x & z) | (y & z);
                        mirror_cells[i][a] = m;
                        mirror_cells[i][b] = m;
                        mirror_cells[i][c] = m;
                        mirror_col_sense[i] = m;
                    end
                end
            OP_WRROW:
                if (a >= N_ROWS) res.status = 1'b1;
                else mirror_cells[a] = mirror_row_sense;
            OP_WRCOL:
                if (a >= N_COLS) res.status = 1'b1;
                else
                begin
                    for (i = 0; i < N_ROWS; i++)
                        mirror_cells[i][a] = mirror_col_sense[i];
                end
            OP_LDROWSA:
                mirror_row_sense = wv;
            OP_LDCOLSA:
                mirror_col_sense = wv;
            OP_SETBIT:
                if (a >= N_ROWS || b >= N_COLS) res.status = 1'b1;
                else mirror_cells[a][b] = wv[0];
            OP_GETBIT:
                if (a >= N_ROWS || b >= N_COLS) res.status = 1'b1;
                else res.read_word = {31'd0, mirror_cells[a][b]};
            OP_SETV:
                if (int'(a) + WORD_BITS > N_ROWS || b >= N_COLS) res.status = 1'b1;
                else
                begin
                    for (i = 0; i < WORD_BITS; i++)
                        mirror_cells[int'(a) + i][b] = wv[i];
                end
            OP_GETV:
                if (int'(a) + WORD_BITS > N_ROWS || b >= N_COLS) res.status = 1'b1;
                else
                begin
                    for (i = 0; i < WORD_BITS; i++)
                        res.read_word[i] = mirror_cells[int'(a) + i][b];
                end
            OP_SETH:
                if (a >= N_ROWS || int'(b) + WORD_BITS > N_COLS) res.status = 1'b1;
                else
                begin
                    for (i = 0; i < WORD_BITS; i++)
                        mirror_cells[a][int'(b) + i] = wv[i];
                end
            OP_GETH:
                if (a >= N_ROWS || int'(b) + WORD_BITS > N_COLS) res.status = 1'b1;
                else
                begin
                    for (i = 0; i < WORD_BITS; i++)
                        res.read_word[i] = mirror_cells[a][int'(b) + i];
                end
            default:
                res.status = 1'b1;
        endcase
        if (res.status)
            res.read_word = '0;
        res.row_sense_value = mirror_row_sense;
        res.col_sense_value = mirror_col_sense;
        awaited_results.push_back(res);
    endtask

    // Present one item at a falling edge, after a random idle gap, and hold it
    // until the block takes it. Valid stays high on return so back-to-back
    // items never see it dropped and raised in the same step.
    task automatic issue_op(input logic [OPCODE_W-1:0] opc,
                            input logic [INDEX_W-1:0] a,
                            input logic [INDEX_W-1:0] b,
                            input logic [INDEX_W-1:0] c,
                            input logic [VALUE_W-1:0] wv);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid        <= 1'b1;
        req_bus.opcode       <= opc;
        req_bus.first_index  <= a;
        req_bus.second_index <= b;
        req_bus.third_index  <= c;
        req_bus.write_value  <= wv;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        apply_to_mirror(opc, a, b, c, wv);
    endtask

    // Drop valid and hold off until every queued result has been returned.
    task automatic rest_until_drained();
        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        return {$urandom, $urandom};
    endfunction

    // Mostly a legal index, sometimes an edge, sometimes out of range.
    function automatic logic [INDEX_W-1:0] pick_index(input int span);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8)
            return INDEX_W'($urandom_range(span, 127));
        if (roll < 11)
            return INDEX_W'(span - 1);
        if (roll < 14)
            return '0;
        return INDEX_W'($urandom_range(0, span - 1));
    endfunction

    // Both sense registers must read back as zero straight out of reset;
    // unused opcodes report them without touching anything.
    task automatic test_reset_state();
        issue_op(OP_UNUSED_LO, '0, '0, '0, '1);
        issue_op(OP_UNUSED_HI, '1, '1, '1, '0);
    endtask

    // Write every row from a random sense pattern so no later read can land
    // on a cell that was never written.
    task automatic fill_array();
        int r;
        for (r = 0; r < N_ROWS; r++)
        begin
            issue_op(OP_LDROWSA, pick_index(N_ROWS), '0, '0, random_value());
            issue_op(OP_WRROW, INDEX_W'(r), pick_index(N_COLS), '0, random_value());
        end
    endtask

    task automatic test_sense_loads();
        issue_op(OP_LDROWSA, '0, '0, '0, '1);
        issue_op(OP_LDCOLSA, '0, '0, '0, '1);
    endtask

    // Single-line reads and write-backs at the array edges, plus index errors.
    task automatic test_lines();
        issue_op(OP_RDROW, INDEX_W'(N_ROWS - 1), '0, '0, '0);
        issue_op(OP_RDCOL, INDEX_W'(N_COLS - 1), '0, '0, '0);
        issue_op(OP_WRROW, '0, '0, '0, '0);
        issue_op(OP_WRCOL, '0, '0, '0, '0);
        issue_op(OP_RDROW, INDEX_W'(N_ROWS), '0, '0, '0);
        issue_op(OP_WRCOL, '1, '0, '0, '0);
    endtask

    // Triple majority: distinct lines, repeated lines, and one line past the end.
    task automatic test_majority();
        issue_op(OP_TRIROW, '0, 7'd1, INDEX_W'(N_ROWS - 1), '0);
        issue_op(OP_TRIROW, 7'd5, 7'd5, 7'd9, '0);
        issue_op(OP_TRICOL, '0, INDEX_W'(N_COLS - 1), INDEX_W'(N_COLS - 1), '0);
        issue_op(OP_TRICOL, 7'd3, 7'd4, INDEX_W'(N_COLS), '0);
    endtask

    task automatic test_bits();
        issue_op(OP_SETBIT, INDEX_W'(N_ROWS - 1), INDEX_W'(N_COLS - 1), '0, 64'd1);
        issue_op(OP_GETBIT, INDEX_W'(N_ROWS - 1), INDEX_W'(N_COLS - 1), '0, '0);
        issue_op(OP_GETBIT, INDEX_W'(N_ROWS), '0, '0, '0);
        issue_op(OP_SETBIT, '0, INDEX_W'(N_COLS), '0, '1);
    endtask

    // Word runs that end exactly on the last row or column, and one step past.
    task automatic test_words();
        issue_op(OP_SETV, INDEX_W'(V_STARTS - 1), INDEX_W'(N_COLS - 1), '0, random_value());
        issue_op(OP_GETV, INDEX_W'(V_STARTS - 1), INDEX_W'(N_COLS - 1), '0, '0);
        issue_op(OP_GETV, INDEX_W'(V_STARTS), '0, '0, '0);
        issue_op(OP_SETH, INDEX_W'(N_ROWS - 1), INDEX_W'(H_STARTS - 1), '0, random_value());
        issue_op(OP_GETH, INDEX_W'(N_ROWS - 1), INDEX_W'(H_STARTS - 1), '0, '0);
        issue_op(OP_SETH, '0, INDEX_W'(H_STARTS), '0, '1);
    endtask

    // Random operations over the whole opcode space; every cell is written
    // by now, so any legal read is in contract.
    task automatic test_random_mix(input int count);
        logic [OPCODE_W-1:0] opc;
        logic [INDEX_W-1:0] a, b, c;
        int n;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 4)
                opc = $urandom_range(1) ? OP_UNUSED_HI : OP_UNUSED_LO;
            else
                opc = OPCODE_W'($urandom_range(OP_RDROW, OP_GETH));
            a = pick_index(N_ROWS);
            b = pick_index(N_COLS);
            c = pick_index(N_ROWS);
            case (opc)
                OP_SETV, OP_GETV:
                    a = pick_index(V_STARTS);
                OP_SETH, OP_GETH:
                    b = pick_index(H_STARTS);
                OP_TRIROW, OP_TRICOL:
                    // Repeat a line now and then.
                    if ($urandom_range(9) == 0)
                        c = $urandom_range(1) ? a : b;
                default: ;
            endcase
            issue_op(opc, a, b, c, random_value());
        end
    endtask

    initial
    begin
        rst_n                = 1'b0;
        req_bus.valid        = 1'b0;
        req_bus.opcode       = '0;
        req_bus.first_index  = '0;
        req_bus.second_index = '0;
        req_bus.third_index  = '0;
        req_bus.write_value  = '0;
        rsp_bus.ready        = 1'b0;
        mismatch_count       = 0;
        mirror_row_sense     = '0;
        mirror_col_sense     = '0;
        foreach (mirror_cells[r])
            mirror_cells[r] = '0;
        src_idle_pct = 13;
        snk_idle_pct = 73;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        fill_array();
        test_sense_loads();
        test_lines();
        test_majority();
        test_bits();
        test_words();
        test_random_mix(480);

        // Hold the sender until everything is back, then swap the idling.
        rest_until_drained();
        src_idle_pct = 73;
        snk_idle_pct = 13;
        test_random_mix(480);

        rest_until_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_mix(480);

        rest_until_drained();
        repeat (HOLD_OFF) @(posedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("tb_pim_subarray_bit_core: done, clean");
        else
            $display("tb_pim_subarray_bit_core: done, errors");
        $finish;
    end

    // Randomize result back-pressure at the falling edge.
    always @(negedge clk)
        rsp_bus.ready <= ($urandom_range(99) >= snk_idle_pct);

    // Compare each returned item with the oldest queued expectation.
    always @(posedge clk)
    begin : check_results
        subarray_result_t want;
        if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch("result returned with none pending");
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_bus.status !== want.status)
                    flag_mismatch($sformatf("status got %0b want %0b",
                                            rsp_bus.status, want.status));
                if (rsp_bus.read_word !== want.read_word)
                    flag_mismatch($sformatf("read_word got %h want %h",
                                            rsp_bus.read_word, want.read_word));
                if (rsp_bus.row_sense_value !== want.row_sense_value)
                    flag_mismatch($sformatf("row_sense_value got %h want %h",
                                            rsp_bus.row_sense_value,
                                            want.row_sense_value));
                if (rsp_bus.col_sense_value !== want.col_sense_value)
                    flag_mismatch($sformatf("col_sense_value got %h want %h",
                                            rsp_bus.col_sense_value,
                                            want.col_sense_value));
            end
        end
    end

    // Advance the quiet counter on every edge with no handshake on either side;
    // a hung block ends the run here.
    always @(posedge clk)
    begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
            $display("tb_pim_subarray_bit_core: done, errors");
            $finish;
        end
    end

    initial
        quiet_cycles = 0;

endmodule

// File: sim.f
+incdir+src
src/psbc_pkg.sv
src/psbc_ifs.sv
src/psbc_ram.sv
src/pim_subarray_bit_core.sv
src/psbc_checker.sv
tb/tb_pim_subarray_bit_core.sv
